// ----- design/ial_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ial_pkg
// shared types and constants of the indexed array list engine
// ----------------------------------------------------------------------------
package ial_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int IDX_W        = 6;
    localparam int VAL_W        = 32;
    localparam int CNT_OUT_W    = 7;

    typedef enum logic [2:0] {
        CMD_APPEND  = 3'd0,
        CMD_SET     = 3'd1,
        CMD_GET     = 3'd2,
        CMD_INSERT  = 3'd3,
        CMD_DELETE  = 3'd4,
        CMD_REVERSE = 3'd5,
        CMD_SORT    = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_RANGE = 2'd1,
        STS_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        COP_HOLD,
        COP_APPEND,
        COP_SET,
        COP_INSERT,
        COP_DELETE,
        COP_TAGS,
        COP_EXCH
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     phase;
        logic     sort;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

// ----- design/ial_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ial_if
// command and result channels of the indexed array list engine
// ----------------------------------------------------------------------------
interface ial_cmd_if import ial_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [2:0]               command;
    logic [IDX_W-1:0]         index;
    logic signed [VAL_W-1:0]  value;

    modport source (output valid, command, index, value, input ready);
    modport sink   (input valid, command, index, value, output ready);
endinterface

interface ial_res_if import ial_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [VAL_W-1:0]  read_value;
    logic [CNT_OUT_W-1:0]     entry_count;
    logic                     is_empty;
    logic                     is_full;

    modport source (output valid, status, read_value, entry_count, is_empty, is_full,
                    input ready);
    modport sink   (input valid, status, read_value, entry_count, is_empty, is_full,
                    output ready);
endinterface

// ----- design/ial_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ial_cell
// one list entry with its position tag, exchanging with its neighbors
// ----------------------------------------------------------------------------
module ial_cell import ial_pkg::*; #(
    parameter int IDX      = 0,
    parameter int XW       = 7
) (
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic [XW-1:0]           i_idx,
    input  logic [XW-1:0]           i_count,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic signed [VAL_W-1:0] i_left_data,
    input  logic [XW-1:0]           i_left_tag,
    input  logic signed [VAL_W-1:0] i_right_data,
    input  logic [XW-1:0]           i_right_tag,
    output logic signed [VAL_W-1:0] o_data,
    output logic [XW-1:0]           o_tag
);

    localparam logic [XW-1:0] OWN  = XW'(IDX);
    localparam logic [XW-1:0] OWN1 = XW'(IDX + 1);

    logic signed [VAL_W-1:0] r_data, n_data;
    logic [XW-1:0]           r_tag, n_tag;
    logic                    w_lower, w_swap_lo, w_swap_hi;

    always_comb begin
        w_lower   = (OWN[0] == i_ctl.phase);
        w_swap_lo = w_lower && (OWN1 < i_count) &&
                    (i_ctl.sort ? (r_data > i_right_data) : (r_tag < i_right_tag));
        w_swap_hi = !w_lower && (OWN != '0) && (OWN < i_count) &&
                    (i_ctl.sort ? (i_left_data > r_data) : (i_left_tag < r_tag));
        n_data = r_data;
        n_tag  = r_tag;
        unique case (i_ctl.op)
            COP_APPEND: if (OWN == i_count) n_data = i_value;
            COP_SET:    if (OWN == i_idx) n_data = i_value;
            COP_INSERT: begin
                if (OWN == i_idx) n_data = i_value;
                else if (OWN > i_idx && OWN <= i_count) n_data = i_left_data;
            end
            COP_DELETE: begin
                if (OWN1 == i_count) n_data = '0;
                else if (OWN >= i_idx && OWN1 < i_count) n_data = i_right_data;
            end
            COP_TAGS:   n_tag = OWN;
            COP_EXCH: begin
                if (w_swap_lo) begin
                    n_data = i_right_data;
                    n_tag  = i_right_tag;
                end else if (w_swap_hi) begin
                    n_data = i_left_data;
                    n_tag  = i_left_tag;
                end
            end
            COP_HOLD:   ;
            default:    ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tag  <= n_tag;
    end

    assign o_data = r_data;
    assign o_tag  = r_tag;

endmodule

// ----- design/indexed_array_list_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_list_engine
// packed list of signed words kept in a row of cells, one command per word
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one entry each; every cell talks
// only to its two neighbors. Append, set, get, insert and delete take effect
// as taken: insert and delete move every later entry one cell over at once.
// Reverse and sort on a list of two or more entries run an odd-even exchange
// pass over neighboring cell pairs (sort compares signed values, reverse
// compares the position tags loaded at its start), and such a command holds
// the command channel until the pass ends. The result word sits in an output
// register; a new command is taken while no pass runs and that register is
// empty or being drained. No clearing pass follows reset.
module indexed_array_list_engine import ial_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ial_cmd_if.sink   i_cmd,
    ial_res_if.source o_res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam int IW = $clog2(CAPACITY);
    localparam logic [XW-1:0] CAP_X  = XW'(CAPACITY);
    localparam logic [CW-1:0] LAST_P = CW'(CAPACITY - 1);

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_phase;
    logic                    r_sort;
    logic                    r_out_valid;
    logic [1:0]              r_status;
    logic signed [VAL_W-1:0] r_rd;
    logic [CNT_OUT_W-1:0]    r_out_count;
    logic                    r_empty, r_full;

    logic                    w_accept, w_in_range, w_is_full, w_start_run, w_done;
    logic                    w_load;
    logic [XW-1:0]           w_idx_x, w_cnt_x;
    t_cell_ctl               w_ctl;
    logic [1:0]              w_status;
    logic signed [VAL_W-1:0] w_rd;

    logic signed [VAL_W-1:0] w_data [CAPACITY];
    logic [XW-1:0]           w_tag  [CAPACITY];

    // handshake and range checks
    assign i_cmd.ready = (r_state == ST_IDLE) && (!r_out_valid || o_res.ready);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_idx_x     = XW'(i_cmd.index);
    assign w_cnt_x     = XW'(r_count);
    assign w_in_range  = w_idx_x < w_cnt_x;
    assign w_is_full   = w_cnt_x == CAP_X;
    assign w_start_run = w_accept && (r_count > CW'(1)) &&
                         (i_cmd.command == CMD_REVERSE || i_cmd.command == CMD_SORT);
    assign w_done      = (r_state == ST_RUN) && (r_phase == LAST_P);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_start_run) n_state = ST_RUN;
            ST_RUN:  if (w_done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // command decode into cell controls, status and new count
    always_comb begin
        w_ctl.op    = COP_HOLD;
        w_ctl.phase = r_phase[0];
        w_ctl.sort  = r_sort;
        w_status    = STS_OK;
        w_rd        = '0;
        n_count     = r_count;
        w_load      = 1'b0;
        if (r_state == ST_RUN) begin
            w_ctl.op = COP_EXCH;
            w_load   = w_done;
        end else if (w_accept) begin
            w_load = !w_start_run;
            unique case (i_cmd.command)
                CMD_APPEND: begin
                    if (w_is_full) w_status = STS_FULL;
                    else begin
                        w_ctl.op = COP_APPEND;
                        n_count  = r_count + CW'(1);
                    end
                end
                CMD_SET: begin
                    if (!w_in_range) w_status = STS_RANGE;
                    else w_ctl.op = COP_SET;
                end
                CMD_GET: begin
                    if (!w_in_range) w_status = STS_RANGE;
                    else w_rd = w_data[w_idx_x[IW-1:0]];
                end
                CMD_INSERT: begin
                    if (!w_in_range) w_status = STS_RANGE;
                    else if (w_is_full) w_status = STS_FULL;
                    else begin
                        w_ctl.op = COP_INSERT;
                        n_count  = r_count + CW'(1);
                    end
                end
                CMD_DELETE: begin
                    if (!w_in_range) w_status = STS_RANGE;
                    else begin
                        w_ctl.op = COP_DELETE;
                        n_count  = r_count - CW'(1);
                    end
                end
                CMD_REVERSE: if (w_start_run) w_ctl.op = COP_TAGS;
                CMD_SORT:    ;
                default:     ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_phase     <= '0;
            r_sort      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_start_run) begin
                r_phase <= '0;
                r_sort  <= (i_cmd.command == CMD_SORT);
            end else if (r_state == ST_RUN) begin
                r_phase <= r_phase + CW'(1);
            end
            if (w_load) r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status    <= w_status;
            r_rd        <= w_rd;
            r_out_count <= CNT_OUT_W'(n_count);
            r_empty     <= (n_count == '0);
            r_full      <= (n_count == CW'(CAPACITY));
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_status;
    assign o_res.read_value  = r_rd;
    assign o_res.entry_count = r_out_count;
    assign o_res.is_empty    = r_empty;
    assign o_res.is_full     = r_full;

    // row of cells, ends tied off
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VAL_W-1:0] w_ld, w_rdat;
        logic [XW-1:0]           w_lt, w_rt;
        if (g == 0) begin : g_left_end
            assign w_ld = '0;
            assign w_lt = '0;
        end else begin : g_left
            assign w_ld = w_data[g-1];
            assign w_lt = w_tag[g-1];
        end
        if (g == CAPACITY - 1) begin : g_right_end
            assign w_rdat = '0;
            assign w_rt   = '0;
        end else begin : g_right
            assign w_rdat = w_data[g+1];
            assign w_rt   = w_tag[g+1];
        end
        ial_cell #(
            .IDX      (g),
            .XW       (XW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_idx        (w_idx_x),
            .i_count      (w_cnt_x),
            .i_value      (i_cmd.value),
            .i_left_data  (w_ld),
            .i_left_tag   (w_lt),
            .i_right_data (w_rdat),
            .i_right_tag  (w_rt),
            .o_data       (w_data[g]),
            .o_tag        (w_tag[g])
        );
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");
    a_no_take_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !i_cmd.ready)
        else $error("command taken during exchange pass");
    a_count_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |=> $stable(r_count))
        else $error("count changed during exchange pass");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_empty && r_full))
        else $error("empty and full together");

endmodule
